// ===== rtl/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit partition allocator: request
// and response words, status codes, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    // Default sizing, overridable on the top level
    localparam int DEF_MEM_SIZE  = 1024;
    localparam int DEF_MAX_PARTS = 16;

    // Fixed field widths of the request and response words
    localparam int OWNER_W = 8;
    localparam int SIZE_W  = 11;
    localparam int BASE_W  = 10;

    // Operation codes carried in the request mode bit
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOOWNER = 2'd3
    } status_t;

    typedef struct packed {
        logic               mode;
        logic [OWNER_W-1:0] owner_id;
        logic [SIZE_W-1:0]  request_size;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [BASE_W-1:0] base_addr;
    } rsp_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_SPLIT_TAIL,
        S_SPLIT_HEAD,
        S_MERGE,
        S_CLOSE,
        S_RESP
    } state_t;

endpackage

// ===== rtl/ffpa_ram.sv =====
// ----------------------------------------------------------------------------
// ffpa_ram
// Partition table storage: one write port, one read port, registered read
// data. A read returns the contents before a write at the same edge.
// ----------------------------------------------------------------------------
module ffpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/first_fit_partition_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_core
// First-fit variable partition allocator with split on allocate and
// coalescing of free neighbors on release.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req) carries one word per operation:
//   mode 0 allocates request_size units for owner_id, mode 1 frees the first
//   busy partition of owner_id. Response channel (rsp_valid/rsp_ready/rsp)
//   returns exactly one word per request: status and base address.
//   The table lives in a single-port-read RAM and one sequencer walks it one
//   entry per cycle; only one request is in flight, req_ready is high only
//   while the sequencer is idle.
//   A zero-size allocate is answered without a table scan. A split opens a
//   slot by moving the entries above the hit up one per cycle, top entry
//   first; a free closes the gap by moving the entries above down one per
//   cycle. The pace is set by the one RAM read port. The next word can be
//   taken in the cycle after the response is loaded. After reset the block
//   writes the initial free partition before it raises req_ready. A stalled
//   response sits in the output register; the next request may be accepted
//   meanwhile and its response waits until that register is taken.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_core #(
    parameter int MEM_SIZE  = ffpa_pkg::DEF_MEM_SIZE,
    parameter int MAX_PARTS = ffpa_pkg::DEF_MAX_PARTS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ffpa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ffpa_pkg::rsp_t rsp
);

    import ffpa_pkg::*;

    localparam int ADDR_W = $clog2(MEM_SIZE);
    localparam int LEN_W  = $clog2(MEM_SIZE + 1);
    localparam int CMP_W  = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;
    localparam int IDX_W  = $clog2(MAX_PARTS);
    localparam int CNT_W  = $clog2(MAX_PARTS + 1);

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [LEN_W-1:0]   length;
        logic               busy;
        logic [OWNER_W-1:0] owner;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sequencer and datapath registers
    state_t             state_reg, state_next;
    logic               mode_reg, mode_next;
    logic [OWNER_W-1:0] owner_reg, owner_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   src_reg, src_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         gap_reg, gap_next;
    logic               left_reg, left_next;
    logic [LEN_W-1:0]   acc_reg, acc_next;
    entry_t             ent_reg, ent_next;
    entry_t             prev_reg, prev_next;
    status_t            st_reg, st_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    // Table port signals
    logic               ram_we;
    logic [CNT_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic [CNT_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata_raw;
    entry_t             ram_rdata;

    // Helper values
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   pos_inc;
    logic [CNT_W-1:0]   src_inc;
    logic [CNT_W-1:0]   src_dec;
    logic               hit;
    logic               right_free;
    logic [CNT_W-1:0]   close_src;

    assign ram_rdata = entry_t'(ram_rdata_raw);
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign pos_inc   = pos_reg + CNT_W'(1);
    assign src_inc   = src_reg + CNT_W'(1);
    assign src_dec   = src_reg - CNT_W'(1);

    ffpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr[IDX_W-1:0]),
        .rdata (ram_rdata_raw)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= CNT_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        owner_reg <= owner_next;
        size_reg  <= size_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        src_reg   <= src_next;
        gap_reg   <= gap_next;
        left_reg  <= left_next;
        acc_reg   <= acc_next;
        ent_reg   <= ent_next;
        prev_reg  <= prev_next;
        st_reg    <= st_next;
        base_reg  <= base_next;
        rsp_reg   <= rsp_next;
    end

    // Match of the entry on the read port against the current request
    always_comb
    begin
        if (mode_reg == MODE_ALLOC)
        begin
            hit = !ram_rdata.busy
                  && (CMP_W'(ram_rdata.length) >= CMP_W'(size_reg));
        end
        else
        begin
            hit = ram_rdata.busy && (ram_rdata.owner == owner_reg);
        end
        right_free = (pos_inc < cnt_reg) && !ram_rdata.busy;
        close_src  = pos_inc + CNT_W'(right_free);
    end

    // Next state, table accesses and response
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        owner_next     = owner_reg;
        size_next      = size_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        gap_next       = gap_reg;
        left_next      = left_reg;
        acc_next       = acc_reg;
        ent_next       = ent_reg;
        prev_next      = prev_reg;
        st_next        = st_reg;
        base_next      = base_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // Write the single free partition covering all memory
                ram_we           = 1'b1;
                ram_waddr        = '0;
                ram_wdata.start  = '0;
                ram_wdata.length = LEN_W'(MEM_SIZE);
                ram_wdata.busy   = 1'b0;
                ram_wdata.owner  = '0;
                state_next       = S_IDLE;
            end

            S_IDLE:
            begin
                // Take a request word and start the scan at entry 0
                req_ready = 1'b1;
                ram_raddr = '0;
                if (req_valid)
                begin
                    mode_next  = req.mode;
                    owner_next = req.owner_id;
                    size_next  = req.request_size;
                    idx_next   = '0;
                    if ((req.mode == MODE_ALLOC) && (req.request_size == '0))
                    begin
                        st_next    = ST_NOFIT;
                        base_next  = '0;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    ent_next = ram_rdata;
                    pos_next = idx_reg;
                    if (mode_reg == MODE_ALLOC)
                    begin
                        if (CMP_W'(ram_rdata.length) == CMP_W'(size_reg))
                        begin
                            // Exact fit: mark busy in place
                            ram_we          = 1'b1;
                            ram_waddr       = idx_reg;
                            ram_wdata       = ram_rdata;
                            ram_wdata.busy  = 1'b1;
                            ram_wdata.owner = owner_reg;
                            st_next         = ST_DONE;
                            base_next       = BASE_W'(ram_rdata.start);
                            state_next      = S_RESP;
                        end
                        else if (cnt_reg == CNT_W'(MAX_PARTS))
                        begin
                            st_next    = ST_FULL;
                            base_next  = '0;
                            state_next = S_RESP;
                        end
                        else if (cnt_reg > idx_inc)
                        begin
                            // Open a slot above the hit, top entry first
                            src_next   = cnt_reg - CNT_W'(1);
                            ram_raddr  = src_next;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_SPLIT_TAIL;
                        end
                    end
                    else
                    begin
                        // Fold a free left neighbor in now, fetch the right one
                        left_next  = (idx_reg != '0) && !prev_reg.busy;
                        acc_next   = ram_rdata.length
                                     + (left_next ? prev_reg.length : LEN_W'(0));
                        ram_raddr  = idx_inc;
                        state_next = S_MERGE;
                    end
                end
                else
                begin
                    prev_next = ram_rdata;
                    if (idx_inc == cnt_reg)
                    begin
                        st_next    = (mode_reg == MODE_ALLOC) ? ST_NOFIT : ST_NOOWNER;
                        base_next  = '0;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        idx_next  = idx_inc;
                        ram_raddr = idx_inc;
                    end
                end
            end

            S_SHIFT:
            begin
                // Move one entry up a place
                ram_we    = 1'b1;
                ram_waddr = src_inc;
                ram_wdata = ram_rdata;
                if (src_reg == pos_inc)
                begin
                    state_next = S_SPLIT_TAIL;
                end
                else
                begin
                    src_next  = src_dec;
                    ram_raddr = src_dec;
                end
            end

            S_SPLIT_TAIL:
            begin
                // Write the remaining free tail after the hit
                ram_we           = 1'b1;
                ram_waddr        = pos_inc;
                ram_wdata.start  = ADDR_W'(CMP_W'(ent_reg.start) + CMP_W'(size_reg));
                ram_wdata.length = LEN_W'(CMP_W'(ent_reg.length) - CMP_W'(size_reg));
                ram_wdata.busy   = 1'b0;
                ram_wdata.owner  = '0;
                state_next       = S_SPLIT_HEAD;
            end

            S_SPLIT_HEAD:
            begin
                // Shrink the hit to the request and mark it busy
                ram_we           = 1'b1;
                ram_waddr        = pos_reg;
                ram_wdata.start  = ent_reg.start;
                ram_wdata.length = LEN_W'(size_reg);
                ram_wdata.busy   = 1'b1;
                ram_wdata.owner  = owner_reg;
                cnt_next         = cnt_reg + CNT_W'(1);
                st_next          = ST_DONE;
                base_next        = BASE_W'(ent_reg.start);
                state_next       = S_RESP;
            end

            S_MERGE:
            begin
                // Write the coalesced free partition, then close the gap
                ram_we           = 1'b1;
                ram_waddr        = left_reg ? (pos_reg - CNT_W'(1)) : pos_reg;
                ram_wdata.start  = left_reg ? prev_reg.start : ent_reg.start;
                ram_wdata.length = acc_reg
                                   + (right_free ? ram_rdata.length : LEN_W'(0));
                ram_wdata.busy   = 1'b0;
                ram_wdata.owner  = '0;
                gap_next         = 2'(left_reg) + 2'(right_free);
                st_next          = ST_DONE;
                base_next        = BASE_W'(ent_reg.start);
                if ((gap_next == 2'd0) || (close_src >= cnt_reg))
                begin
                    cnt_next   = cnt_reg - CNT_W'(gap_next);
                    state_next = S_RESP;
                end
                else
                begin
                    src_next   = close_src;
                    ram_raddr  = close_src;
                    state_next = S_CLOSE;
                end
            end

            S_CLOSE:
            begin
                // Move one entry down by the gap
                ram_we    = 1'b1;
                ram_waddr = src_reg - CNT_W'(gap_reg);
                ram_wdata = ram_rdata;
                if (src_inc == cnt_reg)
                begin
                    cnt_next   = cnt_reg - CNT_W'(gap_reg);
                    state_next = S_RESP;
                end
                else
                begin
                    src_next  = src_inc;
                    ram_raddr = src_inc;
                end
            end

            S_RESP:
            begin
                // Load the output register once it is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status    = st_reg;
                    rsp_next.base_addr = (st_reg == ST_DONE) ? base_reg : '0;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An error word never carries an address
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_DONE) |-> rsp.base_addr == '0)
        else $error("error response with nonzero base address");

    // The table always holds between one and MAX_PARTS entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) && (cnt_reg <= CNT_W'(MAX_PARTS)))
        else $error("partition count out of range");

    // The entry count changes only when a split or a merge completes
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> ($past(state_reg) == S_SPLIT_HEAD)
                              || ($past(state_reg) == S_MERGE)
                              || ($past(state_reg) == S_CLOSE))
        else $error("partition count changed outside split or merge");

    // Only one request is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    // A response word is loaded only from the response state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == S_RESP)
        else $error("response raised outside response state");

endmodule

// ===== bench/first_fit_partition_allocator_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_core_tb
// Drives allocate and free words into the partition allocator and checks
// every response against a shadow copy of the partition table kept here.
// Directed words hit the field extremes, a full table and owner corner
// cases. Random traffic then churns the table with random idling on both
// channels, and a final stretch runs at full rate.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_core_tb;
    import ffpa_pkg::*;

    localparam int TABLE_DEPTH  = DEF_MAX_PARTS;
    localparam int MEM_UNITS    = DEF_MEM_SIZE;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        int                 base;
        int                 len;
        bit                 busy;
        logic [OWNER_W-1:0] owner;
    } seg_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Shadow partition table, updated when a request word is accepted
    seg_t segs [TABLE_DEPTH];
    int   seg_count;

    rsp_t owed_grants [$];
    int   err_cnt = 0;
    int   cycles  = 0;
    bit   gaps_on = 1'b1;

    first_fit_partition_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Drop entry k of the shadow table; later entries move down one place
    function automatic void drop_seg(input int k);
        for (int j = k; j + 1 < seg_count; j++)
            segs[j] = segs[j + 1];
        seg_count--;
        segs[seg_count] = '{0, 0, 1'b0, '0};
    endfunction

    // Apply one request word to the shadow table and return its grant
    function automatic rsp_t apply_request(input req_t item);
        rsp_t grant;
        int   size;
        int   hit;
        hit             = -1;
        size            = item.request_size;
        grant.status    = ST_DONE;
        grant.base_addr = '0;
        if (item.mode == MODE_ALLOC)
        begin
            // first free partition wide enough, in address order
            if (size != 0)
                for (int i = 0; i < seg_count; i++)
                    if (hit < 0 && !segs[i].busy && segs[i].len >= size)
                        hit = i;
            if (hit < 0)
                grant.status = ST_NOFIT;
            else if (segs[hit].len == size)
            begin
                segs[hit].busy  = 1'b1;
                segs[hit].owner = item.owner_id;
                grant.base_addr = segs[hit].base[BASE_W-1:0];
            end
            else if (seg_count >= TABLE_DEPTH)
                grant.status = ST_FULL;
            else
            begin
                // split: head goes busy, tail becomes a new free entry
                for (int j = seg_count; j > hit + 1; j--)
                    segs[j] = segs[j - 1];
                segs[hit + 1] = '{segs[hit].base + size, segs[hit].len - size, 1'b0, '0};
                segs[hit].len   = size;
                segs[hit].busy  = 1'b1;
                segs[hit].owner = item.owner_id;
                seg_count++;
                grant.base_addr = segs[hit].base[BASE_W-1:0];
            end
        end
        else
        begin
            for (int i = 0; i < seg_count; i++)
                if (hit < 0 && segs[i].busy && segs[i].owner == item.owner_id)
                    hit = i;
            if (hit < 0)
                grant.status = ST_NOOWNER;
            else
            begin
                segs[hit].busy  = 1'b0;
                segs[hit].owner = '0;
                grant.base_addr = segs[hit].base[BASE_W-1:0];
                // merge with a free right neighbor, then a free left one
                if (hit + 1 < seg_count && !segs[hit + 1].busy)
                begin
                    segs[hit].len += segs[hit + 1].len;
                    drop_seg(hit + 1);
                end
                if (hit > 0 && !segs[hit - 1].busy)
                begin
                    segs[hit - 1].len += segs[hit].len;
                    drop_seg(hit);
                end
            end
        end
        return grant;
    endfunction

    // Send one request word, optionally after an idle burst, and log its grant
    task automatic send_request(input logic mode, input logic [OWNER_W-1:0] owner,
                                input logic [SIZE_W-1:0] size);
        req_t item;
        item.mode         = mode;
        item.owner_id     = owner;
        item.request_size = size;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        owed_grants.push_back(apply_request(item));
    endtask

    // Zero size, oversize and release of an owner that holds nothing
    task automatic test_edge_requests();
        send_request(MODE_ALLOC, 8'd0, 11'd0);
        send_request(MODE_ALLOC, 8'd255, 11'd2047);
        send_request(MODE_FREE, 8'd7, 11'd0);
    endtask

    // Fill the table, then hit a split on a full table and owner corner cases
    task automatic test_table_full();
        send_request(MODE_ALLOC, 8'd0, 11'd4);
        send_request(MODE_ALLOC, 8'd1, 11'd1);
        send_request(MODE_ALLOC, 8'd255, 11'd3);
        send_request(MODE_ALLOC, 8'd1, 11'd1);
        for (int k = 2; k <= 12; k++)
            send_request(MODE_ALLOC, 8'(k), 11'd1);
        // open a 4-unit hole ahead of an exact 3-unit hole
        send_request(MODE_FREE, 8'd0, 11'd0);
        send_request(MODE_FREE, 8'd255, 11'd2047);
        // first fit needs a split while full; the exact hole is not reached
        send_request(MODE_ALLOC, 8'd100, 11'd3);
        send_request(MODE_ALLOC, 8'd0, 11'd4);
        send_request(MODE_ALLOC, 8'd101, 11'(MEM_UNITS));
        // owner 1 holds two partitions; only the first is released
        send_request(MODE_FREE, 8'd1, 11'd0);
    endtask

    // Random churn of allocations and frees, mostly of live owners
    task automatic test_random_traffic(input int count);
        int                 live [$];
        logic [OWNER_W-1:0] owner;
        logic [SIZE_W-1:0]  size;
        for (int n = 0; n < count; n++)
        begin
            live.delete();
            for (int i = 0; i < seg_count; i++)
                if (segs[i].busy)
                    live.push_back(i);
            if ($urandom_range(0, 99) < 45)
            begin
                if (live.size() != 0 && $urandom_range(0, 99) < 85)
                    owner = segs[live[$urandom_range(0, live.size() - 1)]].owner;
                else
                    owner = 8'($urandom_range(0, 255));
                send_request(MODE_FREE, owner, 11'($urandom_range(0, 2047)));
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                    owner = 8'($urandom_range(1, 12));
                else
                    owner = 8'($urandom_range(0, 255));
                // mostly small sizes so the table fills and fragments
                case ($urandom_range(0, 15))
                    0:       size = 11'($urandom_range(0, 2047));
                    1:       size = 11'($urandom_range(257, 1024));
                    2, 3:    size = 11'($urandom_range(65, 256));
                    default: size = 11'($urandom_range(1, 64));
                endcase
                send_request(MODE_ALLOC, owner, size);
            end
        end
    endtask

    // Response side: stall in random bursts while idling is on
    always @(posedge clk)
    begin : rsp_stall
        int stall_left;
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Compare each accepted response word with the oldest owed grant
    always @(posedge clk)
    begin : check_grants
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (owed_grants.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected response: expected none, actual status %0d base %0d",
                         $time, rsp.status, rsp.base_addr);
            end
            else
            begin
                want = owed_grants.pop_front();
                if (rsp.status !== want.status)
                begin
                    err_cnt++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp.status);
                end
                if (rsp.base_addr !== want.base_addr)
                begin
                    err_cnt++;
                    $display("%0t: base_addr mismatch: expected %0d, actual %0d",
                             $time, want.base_addr, rsp.base_addr);
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        // one free partition spanning all of memory
        for (int i = 0; i < TABLE_DEPTH; i++)
            segs[i] = '{0, 0, 1'b0, '0};
        segs[0].len = MEM_UNITS;
        seg_count   = 1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_edge_requests();
        test_table_full();
        test_random_traffic(1680);
        gaps_on <= 1'b0;
        test_random_traffic(250);
        req_valid <= 1'b0;

        // hold until every grant is in, then watch for strays
        while (owed_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
